// ===== hdl/mfap_pkg.sv =====
// shared constants, request codes and address helper for the max-flow core
// no dependencies
`timescale 1ns / 1ps

package mfap_pkg;

	localparam int NODES     = 32;
	localparam int NODE_W    = $clog2(NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int IDX_W     = 5;
	localparam int CAP_IN_W  = 32;
	localparam int CAP_BITS  = 32;
	localparam int WRK_W     = CAP_BITS + 1;
	localparam int FLOW_BITS = 40;
	localparam int CELLS     = NODES * NODES;
	localparam int ADDR_W    = $clog2(CELLS);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_RUN   = 2'd2;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [ADDR_W-1:0] addr_t;

	function automatic addr_t cell_addr(input node_t u, input node_t v);
		return addr_t'(u) * addr_t'(NODES) + addr_t'(v);
	endfunction

endpackage

// ===== hdl/mfap_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mfap_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/max_flow_augmenting_path_core.sv =====
// max-flow core: capacity store, working residual, dfs path search and augmentation
// depends on mfap_pkg and mfap_ram
`timescale 1ns / 1ps

// Requests are taken when start is high and busy is low. A load writes the
// capacity store directly and leaves busy low. A clear, and the clearing pass
// after reset, hold busy while the capacity store is swept one entry a cycle.
// A run copies the store into the working residual, then searches paths depth
// first, where every neighbour probe is one read of the residual memory; each
// path found then gets a bottleneck pass and an update pass over its edges. A
// run gives flow_out with done high for exactly one cycle, and the receiver
// cannot hold it off; busy falls in that cycle.

module max_flow_augmenting_path_core
	import mfap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [IDX_W-1:0]     from_node,
	input  logic [IDX_W-1:0]     to_node,
	input  logic [CAP_IN_W-1:0]  edge_capacity,
	input  logic                 unlimited,
	input  logic [IDX_W-1:0]     source_node,
	input  logic [IDX_W-1:0]     sink_node,
	output logic                 done,
	output logic [FLOW_BITS-1:0] flow_out
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLR   = 4'd1;
	localparam logic [3:0] ST_CPY   = 4'd2;
	localparam logic [3:0] ST_DINIT = 4'd3;
	localparam logic [3:0] ST_SRD   = 4'd4;
	localparam logic [3:0] ST_SCHK  = 4'd5;
	localparam logic [3:0] ST_NSET  = 4'd6;
	localparam logic [3:0] ST_NRD   = 4'd7;
	localparam logic [3:0] ST_NCHK  = 4'd8;
	localparam logic [3:0] ST_ASET  = 4'd9;
	localparam logic [3:0] ST_ARDF  = 4'd10;
	localparam logic [3:0] ST_AWRF  = 4'd11;
	localparam logic [3:0] ST_AWRB  = 4'd12;

	localparam logic [CAP_BITS-1:0]  CAP_MAX  = '1;
	localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

	logic [3:0]           state_q;
	logic [ADDR_W:0]      cnt_q;
	node_t                src_q, snk_q, top_q, a_q, b_q;
	logic [CNT_W-1:0]     depth_q, cur_q, i_q;
	node_t                stack_q [NODES];
	logic [CNT_W-1:0]     cursor_q [NODES];
	logic [NODES-1:0]     visited_q;
	logic [WRK_W-1:0]     neck_q;
	logic [FLOW_BITS-1:0] total_q;
	logic                 done_q;
	logic [FLOW_BITS-1:0] flow_out_q;
	logic                 cv_s1;
	addr_t                ca_s1;

	logic                 st_we;
	addr_t                st_waddr, st_raddr;
	logic [CAP_BITS-1:0]  st_wdata, st_rdata;
	logic                 wk_we;
	addr_t                wk_waddr, wk_raddr;
	logic [WRK_W-1:0]     wk_wdata, wk_rdata;

	logic                 accept;
	logic [CAP_BITS-1:0]  cap_in;
	node_t                stk_rd, cur_v;
	logic [NODE_W-1:0]    stk_idx;
	logic [FLOW_BITS:0]   flow_sum;
	logic                 bad_run;

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign flow_out = flow_out_q;
	assign accept   = start && !busy;
	assign cur_v    = cur_q[NODE_W-1:0];

	assign cap_in = (unlimited || ({32'd0, edge_capacity} > 64'(CAP_MAX)))
		? CAP_MAX : CAP_BITS'(edge_capacity);

	assign bad_run = (32'(source_node) >= NODES) || (32'(sink_node) >= NODES)
		|| (source_node == sink_node);

	assign flow_sum = {1'b0, total_q} + (FLOW_BITS+1)'(neck_q);

	always_comb begin
		stk_idx = i_q[NODE_W-1:0];
		if (state_q == ST_SRD) begin
			stk_idx = NODE_W'(depth_q - CNT_W'(2));
		end
	end
	assign stk_rd = stack_q[stk_idx];

	always_comb begin
		st_we    = 1'b0;
		st_waddr = cnt_q[ADDR_W-1:0];
		st_wdata = '0;
		st_raddr = cnt_q[ADDR_W-1:0];
		if (state_q == ST_CLR) begin
			st_we = 1'b1;
		end else if (accept && req_type == REQ_LOAD && 32'(from_node) < NODES
			&& 32'(to_node) < NODES) begin
			st_we    = 1'b1;
			st_waddr = cell_addr(node_t'(from_node), node_t'(to_node));
			st_wdata = cap_in;
		end
	end

	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = ca_s1;
		wk_wdata = WRK_W'(st_rdata);
		wk_raddr = cell_addr(top_q, cur_v);
		if (cv_s1) begin
			wk_we = 1'b1;
		end
		unique case (state_q)
			ST_NRD, ST_ARDF: begin
				wk_raddr = cell_addr(a_q, stk_rd);
			end
			ST_AWRF: begin
				wk_we    = 1'b1;
				wk_waddr = cell_addr(a_q, b_q);
				wk_wdata = wk_rdata - neck_q;
				wk_raddr = cell_addr(b_q, a_q);
			end
			ST_AWRB: begin
				wk_we    = 1'b1;
				wk_waddr = cell_addr(b_q, a_q);
				wk_wdata = wk_rdata + neck_q;
			end
			default: begin
			end
		endcase
	end

	mfap_ram #(.W(CAP_BITS), .DEPTH(CELLS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mfap_ram #(.W(WRK_W), .DEPTH(CELLS)) u_work (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.raddr (wk_raddr),
		.rdata (wk_rdata)
	);

	// copy pipeline tracks the store read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
		end else begin
			cv_s1 <= (state_q == ST_CPY) && (cnt_q != (ADDR_W+1)'(CELLS));
		end
	end

	always_ff @(posedge clk) begin
		ca_s1 <= cnt_q[ADDR_W-1:0];
	end

	// result strobe: rejected run or search exhausted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && req_type == REQ_RUN && bad_run)
				|| (state_q == ST_SRD && cur_q == CNT_W'(NODES) && depth_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			cnt_q      <= '0;
			depth_q    <= '0;
			visited_q  <= '0;
			total_q    <= '0;
			flow_out_q <= '0;
			src_q      <= '0;
			snk_q      <= '0;
			top_q      <= '0;
			a_q        <= '0;
			b_q        <= '0;
			cur_q      <= '0;
			i_q        <= '0;
			neck_q     <= '0;
			stack_q    <= '{default: '0};
			cursor_q   <= '{default: '0};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLR;
							end
							REQ_RUN: begin
								total_q <= '0;
								src_q   <= node_t'(source_node);
								snk_q   <= node_t'(sink_node);
								if (bad_run) begin
									flow_out_q <= '0;
								end else begin
									cnt_q   <= '0;
									state_q <= ST_CPY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CPY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (ADDR_W+1)'(CELLS)) begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					visited_q         <= NODES'(1) << src_q;
					stack_q[0]        <= src_q;
					top_q             <= src_q;
					depth_q           <= CNT_W'(1);
					cur_q             <= '0;
					state_q           <= ST_SRD;
				end
				ST_SRD: begin
					if (cur_q == CNT_W'(NODES)) begin
						if (depth_q == CNT_W'(1)) begin
							depth_q    <= '0;
							flow_out_q <= total_q;
							state_q    <= ST_IDLE;
						end else begin
							depth_q <= depth_q - 1'b1;
							top_q   <= stk_rd;
							cur_q   <= cursor_q[stk_idx];
						end
					end else begin
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					if (wk_rdata != '0 && !visited_q[cur_v]) begin
						cursor_q[NODE_W'(depth_q - 1'b1)] <= cur_q + 1'b1;
						stack_q[depth_q[NODE_W-1:0]]      <= cur_v;
						depth_q <= depth_q + 1'b1;
						top_q   <= cur_v;
						cur_q   <= '0;
						if (cur_v == snk_q) begin
							state_q <= ST_NSET;
						end else begin
							visited_q[cur_v] <= 1'b1;
							state_q          <= ST_SRD;
						end
					end else begin
						cur_q   <= cur_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_NSET: begin
					a_q     <= stack_q[0];
					i_q     <= CNT_W'(1);
					neck_q  <= '1;
					state_q <= ST_NRD;
				end
				ST_NRD: begin
					b_q     <= stk_rd;
					state_q <= ST_NCHK;
				end
				ST_NCHK: begin
					if (wk_rdata < neck_q) begin
						neck_q <= wk_rdata;
					end
					a_q <= b_q;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == depth_q) begin
						state_q <= ST_ASET;
					end else begin
						state_q <= ST_NRD;
					end
				end
				ST_ASET: begin
					total_q <= flow_sum[FLOW_BITS] ? FLOW_MAX : flow_sum[FLOW_BITS-1:0];
					a_q     <= stack_q[0];
					i_q     <= CNT_W'(1);
					state_q <= ST_ARDF;
				end
				ST_ARDF: begin
					b_q     <= stk_rd;
					state_q <= ST_AWRF;
				end
				ST_AWRF: begin
					state_q <= ST_AWRB;
				end
				ST_AWRB: begin
					a_q <= b_q;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == depth_q) begin
						state_q <= ST_DINIT;
					end else begin
						state_q <= ST_ARDF;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy) else $error("result transfer while busy");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCHK) |-> (depth_q != '0 && depth_q < CNT_W'(NODES)))
		else $error("search depth out of range");

	a_src_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRD) |-> visited_q[src_q]) else $error("source not marked");

	a_edge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AWRF) |-> (a_q != b_q)) else $error("path edge is a loop");
`endif

endmodule
